// ===== rtl/core/bpsa_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the slot allocator.
`timescale 1ns / 1ps

package bpsa_pkg;

  // Pool geometry.
  localparam int POOL_SIZE = 16;
  localparam int IDX_W     = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CNT_W     = $clog2(POOL_SIZE + 1);

  // Field widths fixed by the interface.
  localparam int SLOT_W  = 8;
  localparam int LIFE_W  = 8;
  localparam int FREE_W  = 9;
  localparam int CIDX_W  = 2;

  localparam logic [LIFE_W-1:0] LIFE_NO_AGING = 8'hFF;

  // Action codes.
  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_AGING    = 2'd0;
  localparam logic [CIDX_W-1:0] REG_LIFETIME = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic start;   // capture the item and set up the sweep
    logic step;    // process one slot
    logic finish;  // load the result register
  } cmd_t;

  typedef struct packed {
    logic last_step;
    logic out_valid;
  } sts_t;

endpackage

// ===== rtl/core/buffer_pool_slot_allocator_core.sv =====
// Top level of the buffer pool slot allocator: controller, datapath and port wiring.
`timescale 1ns / 1ps

// Next-fit allocator for a fixed pool of POOL_SIZE message buffer slots (16 as built), each
// holding an 8-bit lifetime where zero means free. Every input beat (allocate, release or
// clear) produces exactly one result beat carrying the grant flag, the granted slot and the
// number of free slots afterwards. Each beat is accepted, then the lifetime registers are
// swept at one slot per cycle, and then the result register is loaded. The sweep both carries
// out the action and counts the free slots. The next beat is accepted as soon as the result
// has been loaded, even if the previous result has not yet been taken; the result register
// only holds back that load when it is still full at the end of the sweep. Configuration
// writes are always accepted and must only be issued while no beat is in flight. Reset frees
// every slot at once, so there is no clearing pass.

module buffer_pool_slot_allocator_core (
  input  logic                          clk,
  input  logic                          rst,
  // Input channel.
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    action,
  input  logic [bpsa_pkg::SLOT_W-1:0]   slot,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          granted,
  output logic [bpsa_pkg::SLOT_W-1:0]   granted_slot,
  output logic [bpsa_pkg::FREE_W-1:0]   free_count,
  // Configuration write channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bpsa_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [bpsa_pkg::LIFE_W-1:0]   cfg_data
);
  import bpsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The configuration registers have no side effects, so a write beat is taken at once.
  assign cfg_ready = 1'b1;

  // The controller only sequences; all state that the result depends on lives in the
  // datapath, which is steered by the start, step and finish commands.
  bpsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath sweeps from the slot after the search pointer, wrapping round, so an
  // allocation grants the first free slot in next-fit order. A release also ages the other
  // busy slots when aging is on, and a slot index beyond the pool matches nothing.
  bpsa_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .action       (action),
    .slot         (slot),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .granted      (granted),
    .granted_slot (granted_slot),
    .free_count   (free_count)
  );

endmodule

// ===== rtl/core/bpsa_ctrl.sv =====
// Controller state machine sequencing accept, slot sweep and result load.
`timescale 1ns / 1ps

module bpsa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_ready,
  input  bpsa_pkg::sts_t sts,
  output bpsa_pkg::cmd_t cmd
);
  import bpsa_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (sts.last_step) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts.out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.start  = 1'b0;
    cmd.step   = 1'b0;
    cmd.finish = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_SWEEP: begin
        cmd.step = 1'b1;
      end
      ST_FINISH: begin
        cmd.finish = !sts.out_valid || out_ready;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/bpsa_datapath.sv =====
// Datapath: slot lifetime registers, search pointer, configuration and result register.
`timescale 1ns / 1ps

module bpsa_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  bpsa_pkg::cmd_t                cmd,
  output bpsa_pkg::sts_t                sts,
  input  logic [1:0]                    action,
  input  logic [bpsa_pkg::SLOT_W-1:0]   slot,
  input  logic                          cfg_valid,
  input  logic [bpsa_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [bpsa_pkg::LIFE_W-1:0]   cfg_data,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          granted,
  output logic [bpsa_pkg::SLOT_W-1:0]   granted_slot,
  output logic [bpsa_pkg::FREE_W-1:0]   free_count
);
  import bpsa_pkg::*;

  logic [LIFE_W-1:0] life [POOL_SIZE];
  logic [IDX_W-1:0]  ptr;
  logic              aging;
  logic [LIFE_W-1:0] lifetime;

  logic [1:0]        act_q;
  logic [SLOT_W-1:0] slot_q;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  cnt;
  logic [CNT_W-1:0]  acc;
  logic              found;
  logic [IDX_W-1:0]  gslot;

  logic [LIFE_W-1:0] cur;
  logic [LIFE_W-1:0] life_next;
  logic [LIFE_W-1:0] alloc_life;
  logic              grant_now;
  logic [IDX_W-1:0]  idx_inc;
  logic [IDX_W-1:0]  start_idx;

  assign cur        = life[idx];
  assign idx_inc    = (idx == IDX_W'(POOL_SIZE - 1)) ? '0 : idx + 1'b1;
  assign start_idx  = (ptr == IDX_W'(POOL_SIZE - 1)) ? '0 : ptr + 1'b1;
  assign alloc_life = !aging ? LIFE_NO_AGING :
                      (lifetime == '0) ? LIFE_W'(1) : lifetime;

  always_comb begin
    life_next = cur;
    grant_now = 1'b0;
    unique case (act_q)
      ACT_ALLOC: begin
        if (!found && cur == '0) begin
          life_next = alloc_life;
          grant_now = 1'b1;
        end
      end
      ACT_RELEASE: begin
        if (slot_q == SLOT_W'(idx)) begin
          life_next = '0;
        end else if (aging && cur != '0) begin
          life_next = cur - 1'b1;
        end
      end
      ACT_CLEAR: life_next = '0;
      default:   life_next = cur;
    endcase
  end

  assign sts.last_step = (cnt == IDX_W'(POOL_SIZE - 1));
  assign sts.out_valid = out_valid;

  // Control state: lifetimes, pointer, configuration, result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < POOL_SIZE; i++) begin
        life[i] <= '0;
      end
      ptr       <= IDX_W'(POOL_SIZE - 1);
      aging     <= 1'b0;
      lifetime  <= LIFE_W'(64);
      out_valid <= 1'b0;
    end else begin
      if (cmd.step) begin
        life[idx] <= life_next;
        if (grant_now) ptr <= idx;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_AGING:    aging    <= cfg_data[0];
          REG_LIFETIME: lifetime <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Sweep registers and result payload.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      act_q  <= action;
      slot_q <= slot;
      idx    <= start_idx;
      cnt    <= '0;
      acc    <= '0;
      found  <= 1'b0;
      gslot  <= '0;
    end else if (cmd.step) begin
      idx <= idx_inc;
      cnt <= cnt + 1'b1;
      acc <= acc + CNT_W'(life_next == '0);
      if (grant_now) begin
        found <= 1'b1;
        gslot <= idx;
      end
    end
    if (cmd.finish) begin
      granted      <= found;
      granted_slot <= SLOT_W'(gslot);
      free_count   <= FREE_W'(acc);
    end
  end

endmodule
